// File: rtl/chirp_square_wave_points_core_defines.svh
// Assertion macros shared by the chirp square wave point generator.
`ifndef CHIRP_SQUARE_WAVE_POINTS_CORE_DEFINES_SVH
`define CHIRP_SQUARE_WAVE_POINTS_CORE_DEFINES_SVH

// Checks that the consequence holds in the same cycle as the antecedent.
`define CSW_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Checks that the consequence holds in the cycle after the antecedent.
`define CSW_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/csw_pkg.sv
// Shared types, constants and helper functions of the chirp square wave generator.
package csw_pkg;

    localparam int TICKS_PER_SECOND = 1000000;
    localparam int MAX_POINTS       = 5000;
    localparam int MHZ_PER_HZ       = 1000;
    localparam int RATE_FRAC        = 23;
    // Ticks per millisecond in Q.16 time: TICKS_PER_SECOND * 65536 / 1000.
    localparam longint PERIOD_SCALE = longint'(TICKS_PER_SECOND) * 8192 / 125;

    localparam int AMP_W    = 15;
    localparam int FREQ_W   = 24;
    localparam int PER_W    = 22;
    localparam int LEVEL_W  = 16;
    localparam int DUR_W    = 40;
    localparam int STS_W    = 2;
    localparam int IDX_W    = 13;
    localparam int FQ_W     = 40;
    localparam int TIME_W   = 56;
    localparam int PT_W     = 48;
    localparam int RATE_W   = 48;
    localparam int DIV_N_W  = 64;
    localparam int DIV_D_W  = 42;
    localparam int PROD_W   = RATE_W + TIME_W;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 24;

    // Numerator of the half period division: TICKS_PER_SECOND*500 * 2^33.
    localparam logic [DIV_N_W-1:0] HP_NUM =
        (64'(TICKS_PER_SECOND) * 64'd500) << 33;
    localparam logic [TIME_W-1:0] TIME_MAX = '1;
    localparam logic [FQ_W-1:0]   FREQ_MAX = '1;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_AMPLITUDE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_START     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_END       = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_PERIOD    = 2'd3;

    // Result status codes.
    localparam logic [STS_W-1:0] ST_OK   = 2'd0;
    localparam logic [STS_W-1:0] ST_MAX  = 2'd1;
    localparam logic [STS_W-1:0] ST_IDLE = 2'd2;

    typedef enum logic [1:0] {
        DSEL_RATE,
        DSEL_HP_START,
        DSEL_HP_NEXT
    } t_div_sel;

    typedef enum logic [1:0] {
        K_POINT,
        K_MAX,
        K_IDLE
    } t_kind;

    typedef struct packed {
        logic     rate_prep;
        logic     div_go;
        t_div_sel div_sel;
        logic     latch_rate;
        logic     latch_hp;
        logic     mul_go;
        logic     freq_upd;
        logic     latch_next;
        logic     decide;
        logic     emit;
        t_kind    kind;
    } t_cmd;

    typedef struct packed {
        logic start_bad;
        logic idx_full;
        logic div_busy;
        logic mul_busy;
        logic last;
    } t_sts;

    // Rounds a doubled quotient half up and saturates it to the time range.
    function automatic logic [TIME_W-1:0] hp_round(input logic [DIV_N_W-1:0] q);
        logic [DIV_N_W:0] s;
        s = {1'b0, q} + 65'd1;
        if (|s[DIV_N_W:TIME_W+1]) begin
            return TIME_MAX;
        end
        return s[TIME_W:1];
    endfunction

    // Converts Q.16 time to whole ticks, rounded half up and saturated.
    function automatic logic [DUR_W-1:0] to_ticks(input logic [TIME_W-1:0] t);
        logic [TIME_W:0] s;
        s = {1'b0, t} + 57'h8000;
        if (s[TIME_W]) begin
            return '1;
        end
        return s[TIME_W-1:16];
    endfunction

endpackage

// File: rtl/csw_ifs.sv
// Handshake channel interfaces: request input, result output and configuration writes.
interface csw_in_if;
    logic valid;
    logic ready;
    logic restart;
    modport source (output valid, output restart, input ready);
    modport sink (input valid, input restart, output ready);
endinterface

interface csw_out_if;
    logic valid;
    logic ready;
    logic signed [csw_pkg::LEVEL_W-1:0] level;
    logic [csw_pkg::DUR_W-1:0] duration_ticks;
    logic last;
    logic [csw_pkg::STS_W-1:0] status;
    modport source (output valid, output level, output duration_ticks, output last,
                    output status, input ready);
    modport sink (input valid, input level, input duration_ticks, input last,
                  input status, output ready);
endinterface

interface csw_cfg_if;
    logic valid;
    logic ready;
    logic [csw_pkg::CFG_IDX_W-1:0] index;
    logic [csw_pkg::CFG_DAT_W-1:0] data;
    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

// File: rtl/csw_div.sv
// Restoring divider that produces one quotient bit per cycle.
module csw_div (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_go,
    input  logic [csw_pkg::DIV_N_W-1:0]   i_num,
    input  logic [csw_pkg::DIV_D_W-1:0]   i_den,
    output logic                          o_busy,
    output logic [csw_pkg::DIV_N_W-1:0]   o_quo
);
    import csw_pkg::*;

    localparam int CNT_W = $clog2(DIV_N_W);

    logic                r_busy;
    logic [CNT_W-1:0]    r_cnt;
    logic [DIV_N_W-1:0]  r_num;
    logic [DIV_N_W-1:0]  r_quo;
    logic [DIV_D_W-1:0]  r_den;
    logic [DIV_D_W-1:0]  r_rem;
    logic [DIV_D_W:0]    rem_sh;
    logic                fits;

    // Shift in the next numerator bit and try a subtraction.
    assign rem_sh = {r_rem, r_num[DIV_N_W-1]};
    assign fits   = rem_sh >= {1'b0, r_den};

    // Control state of the iteration.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_go) begin
            r_busy <= 1'b1;
            r_cnt  <= '0;
        end else if (r_busy) begin
            r_cnt <= r_cnt + 1'b1;
            if (r_cnt == CNT_W'(DIV_N_W - 1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    // Partial remainder and quotient.
    always_ff @(posedge i_clk) begin
        if (i_go) begin
            r_num <= i_num;
            r_den <= i_den;
            r_rem <= '0;
            r_quo <= '0;
        end else if (r_busy) begin
            r_num <= {r_num[DIV_N_W-2:0], 1'b0};
            r_quo <= {r_quo[DIV_N_W-2:0], fits};
            r_rem <= fits ? DIV_D_W'(rem_sh - {1'b0, r_den}) : rem_sh[DIV_D_W-1:0];
        end
    end

    assign o_busy = r_busy;
    assign o_quo  = r_quo;
endmodule

// File: rtl/csw_mul.sv
// Shift-and-add multiplier that consumes one multiplier bit per cycle, MSB first.
module csw_mul (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_go,
    input  logic [csw_pkg::RATE_W-1:0]    i_a,
    input  logic [csw_pkg::TIME_W-1:0]    i_b,
    output logic                          o_busy,
    output logic [csw_pkg::PROD_W-1:0]    o_prod
);
    import csw_pkg::*;

    localparam int CNT_W = $clog2(RATE_W);

    logic               r_busy;
    logic [CNT_W-1:0]   r_cnt;
    logic [RATE_W-1:0]  r_a;
    logic [TIME_W-1:0]  r_b;
    logic [PROD_W-1:0]  r_prod;

    // Iteration control.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_go) begin
            r_busy <= 1'b1;
            r_cnt  <= '0;
        end else if (r_busy) begin
            r_cnt <= r_cnt + 1'b1;
            if (r_cnt == CNT_W'(RATE_W - 1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    // Accumulate the partial products.
    always_ff @(posedge i_clk) begin
        if (i_go) begin
            r_a    <= i_a;
            r_b    <= i_b;
            r_prod <= '0;
        end else if (r_busy) begin
            r_a    <= {r_a[RATE_W-2:0], 1'b0};
            r_prod <= {r_prod[PROD_W-2:0], 1'b0}
                      + (r_a[RATE_W-1] ? PROD_W'(r_b) : '0);
        end
    end

    assign o_busy = r_busy;
    assign o_prod = r_prod;
endmodule

// File: rtl/csw_dp.sv
// Datapath: configuration registers, sweep state, arithmetic units and result register.
module csw_dp (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_cfg_we,
    input  logic [csw_pkg::CFG_IDX_W-1:0]        i_cfg_index,
    input  logic [csw_pkg::CFG_DAT_W-1:0]        i_cfg_data,
    input  csw_pkg::t_cmd                        i_cmd,
    output csw_pkg::t_sts                        o_sts,
    output logic signed [csw_pkg::LEVEL_W-1:0]   o_level,
    output logic [csw_pkg::DUR_W-1:0]            o_duration_ticks,
    output logic                                 o_last,
    output logic [csw_pkg::STS_W-1:0]            o_status
);
    import csw_pkg::*;

    logic [AMP_W-1:0]    r_amp;
    logic [FREQ_W-1:0]   r_start;
    logic [FREQ_W-1:0]   r_end;
    logic [PER_W-1:0]    r_period;

    logic [DIV_N_W-1:0]  r_rnum;
    logic [DIV_D_W-1:0]  r_rden;
    logic                r_rneg;
    logic [RATE_W-1:0]   r_rate_mag;
    logic [FQ_W-1:0]     r_freq;
    logic [FQ_W-1:0]     r_next_f;
    logic [TIME_W-1:0]   r_hp;
    logic [TIME_W-1:0]   r_next_hp;
    logic [TIME_W-1:0]   r_elapsed;
    logic [PT_W-1:0]     r_period_t;
    logic [IDX_W-1:0]    r_idx;
    logic                r_last;
    logic [DUR_W-1:0]    r_dur;

    logic signed [LEVEL_W-1:0] r_level;
    logic [DUR_W-1:0]          r_out_dur;
    logic                      r_out_last;
    logic [STS_W-1:0]          r_out_sts;

    logic [FREQ_W-1:0]   diff;
    logic [DIV_N_W-1:0]  div_num;
    logic [DIV_D_W-1:0]  div_den;
    logic                div_busy;
    logic [DIV_N_W-1:0]  div_quo;
    logic                mul_busy;
    logic [PROD_W-1:0]   prod;
    logic [TIME_W-1:0]   hp_new;
    logic [FQ_W:0]       inc_raw;
    logic [FQ_W:0]       inc;
    logic [FQ_W+1:0]     f_sum;
    logic [FQ_W-1:0]     f_new;
    logic [TIME_W+1:0]   span;
    logic                over;
    logic signed [LEVEL_W-1:0] lvl;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_amp    <= '0;
            r_start  <= FREQ_W'(1000);
            r_end    <= FREQ_W'(1000);
            r_period <= PER_W'(1000);
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_AMPLITUDE: r_amp    <= i_cfg_data[AMP_W-1:0];
                REG_START:     r_start  <= i_cfg_data[FREQ_W-1:0];
                REG_END:       r_end    <= i_cfg_data[FREQ_W-1:0];
                REG_PERIOD:    r_period <= i_cfg_data[PER_W-1:0];
                default: ;
            endcase
        end
    end

    // Divider operand selection.
    assign diff = (r_end >= r_start) ? r_end - r_start : r_start - r_end;

    always_comb begin
        div_num = HP_NUM;
        div_den = '0;
        case (i_cmd.div_sel)
            DSEL_RATE: begin
                div_num = r_rnum;
                div_den = r_rden;
            end
            DSEL_HP_START: div_den = DIV_D_W'({r_start, 16'h0000});
            DSEL_HP_NEXT:  div_den = DIV_D_W'(r_next_f);
            default: ;
        endcase
    end

    csw_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_go    (i_cmd.div_go),
        .i_num   (div_num),
        .i_den   (div_den),
        .o_busy  (div_busy),
        .o_quo   (div_quo)
    );

    csw_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_go    (i_cmd.mul_go),
        .i_a     (r_rate_mag),
        .i_b     (r_hp),
        .o_busy  (mul_busy),
        .o_prod  (prod)
    );

    assign hp_new = hp_round(div_quo);

    // Frequency step: saturate the scaled product, then move toward the end frequency.
    assign inc_raw = prod[FQ_W+RATE_FRAC:RATE_FRAC];
    assign inc = ((|prod[PROD_W-1:DIV_N_W]) || (inc_raw > {1'b1, {FQ_W{1'b0}}}))
                 ? {1'b1, {FQ_W{1'b0}}} : inc_raw;
    assign f_sum = {2'b00, r_freq} + {1'b0, inc};

    always_comb begin
        if (r_rneg) begin
            f_new = ({1'b0, r_freq} <= inc) ? FQ_W'(1) : r_freq - inc[FQ_W-1:0];
        end else begin
            f_new = (f_sum > {2'b00, FREQ_MAX}) ? FREQ_MAX : f_sum[FQ_W-1:0];
        end
    end

    // Look-ahead test: does the next half period still fit in the sweep?
    assign span = {2'b00, r_elapsed} + {2'b00, r_hp} + {2'b00, r_next_hp};
    assign over = span > (TIME_W+2)'(r_period_t);
    assign lvl  = r_idx[0] ? -$signed({1'b0, r_amp}) : $signed({1'b0, r_amp});

    // Sweep state and the stages of one point.
    always_ff @(posedge i_clk) begin
        if (i_cmd.rate_prep) begin
            r_rnum <= DIV_N_W'((34'(diff) * 34'(MHZ_PER_HZ))) << RATE_FRAC;
            r_rden <= DIV_D_W'(r_period) * DIV_D_W'(TICKS_PER_SECOND);
            r_rneg <= r_end < r_start;
        end
        if (i_cmd.latch_rate) begin
            r_rate_mag <= div_quo[RATE_W-1:0];
            r_freq     <= {r_start, 16'h0000};
            r_elapsed  <= '0;
            r_idx      <= '0;
        end
        if (i_cmd.latch_hp) begin
            r_hp <= hp_new;
        end
        if (i_cmd.freq_upd) begin
            r_next_f <= f_new;
        end
        if (i_cmd.latch_next) begin
            r_next_hp  <= hp_new;
            r_period_t <= PT_W'(r_period) * PT_W'(PERIOD_SCALE);
        end
        if (i_cmd.decide) begin
            r_last <= over;
            if (!over) begin
                r_dur <= to_ticks(r_hp);
            end else if (TIME_W'(r_period_t) <= r_elapsed) begin
                r_dur <= '0;
            end else begin
                r_dur <= to_ticks(TIME_W'(r_period_t) - r_elapsed);
            end
        end
        if (i_cmd.emit && i_cmd.kind == K_POINT && !r_last) begin
            r_elapsed <= r_elapsed + r_hp;
            r_freq    <= r_next_f;
            r_hp      <= r_next_hp;
            r_idx     <= r_idx + 1'b1;
        end
    end

    // Result register.
    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            if (i_cmd.kind == K_POINT) begin
                r_level    <= lvl;
                r_out_dur  <= r_dur;
                r_out_last <= r_last;
                r_out_sts  <= ST_OK;
            end else begin
                r_level    <= '0;
                r_out_dur  <= '0;
                r_out_last <= 1'b0;
                r_out_sts  <= (i_cmd.kind == K_MAX) ? ST_MAX : ST_IDLE;
            end
        end
    end

    assign o_sts.start_bad = (r_start == '0) || (r_period == '0);
    assign o_sts.idx_full  = r_idx >= IDX_W'(MAX_POINTS);
    assign o_sts.div_busy  = div_busy;
    assign o_sts.mul_busy  = mul_busy;
    assign o_sts.last      = r_last;

    assign o_level          = r_level;
    assign o_duration_ticks = r_out_dur;
    assign o_last           = r_out_last;
    assign o_status         = r_out_sts;
endmodule

// File: rtl/csw_ctrl.sv
// Controller: sequences the divider, multiplier and result register for each request.
`include "chirp_square_wave_points_core_defines.svh"

module csw_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    input  logic           i_restart,
    output logic           o_in_ready,
    output logic           o_out_valid,
    input  logic           i_out_ready,
    output csw_pkg::t_cmd  o_cmd,
    input  csw_pkg::t_sts  i_sts
);
    import csw_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE,
        S_RATE_GO,
        S_RATE_DIV,
        S_HP0_DIV,
        S_MUL_GO,
        S_MUL,
        S_NEXT_GO,
        S_NEXT_DIV,
        S_DECIDE,
        S_EMIT
    } t_state;

    t_state r_state;
    t_kind  r_kind;
    logic   r_running;
    logic   r_out_valid;
    logic   accept;
    logic   out_free;
    logic   units_busy;
    logic   err_emit;
    logic   mid_emit;
    t_cmd   cmd;

    assign accept   = (r_state == S_IDLE) && i_in_valid;
    assign out_free = !r_out_valid || i_out_ready;

    // Command decode from the current state.
    always_comb begin
        cmd         = '0;
        cmd.kind    = r_kind;
        cmd.div_sel = DSEL_RATE;
        unique case (r_state)
            S_IDLE:     cmd.rate_prep = accept && i_restart && !i_sts.start_bad;
            S_RATE_GO:  cmd.div_go = 1'b1;
            S_RATE_DIV: begin
                if (!i_sts.div_busy) begin
                    cmd.latch_rate = 1'b1;
                    cmd.div_go     = 1'b1;
                    cmd.div_sel    = DSEL_HP_START;
                end
            end
            S_HP0_DIV:  cmd.latch_hp = !i_sts.div_busy;
            S_MUL_GO:   cmd.mul_go = 1'b1;
            S_MUL:      cmd.freq_upd = !i_sts.mul_busy;
            S_NEXT_GO: begin
                cmd.div_go  = 1'b1;
                cmd.div_sel = DSEL_HP_NEXT;
            end
            S_NEXT_DIV: cmd.latch_next = !i_sts.div_busy;
            S_DECIDE:   cmd.decide = 1'b1;
            S_EMIT:     cmd.emit = out_free;
            default: ;
        endcase
    end

    // State, sweep activity and output valid.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_kind      <= K_IDLE;
            r_running   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (cmd.emit) begin
                r_out_valid <= 1'b1;
                r_running   <= (r_kind == K_POINT) && !i_sts.last;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        if (i_restart) begin
                            r_running <= 1'b0;
                            if (i_sts.start_bad) begin
                                r_kind  <= K_IDLE;
                                r_state <= S_EMIT;
                            end else begin
                                r_kind  <= K_POINT;
                                r_state <= S_RATE_GO;
                            end
                        end else if (!r_running) begin
                            r_kind  <= K_IDLE;
                            r_state <= S_EMIT;
                        end else if (i_sts.idx_full) begin
                            r_running <= 1'b0;
                            r_kind    <= K_MAX;
                            r_state   <= S_EMIT;
                        end else begin
                            r_kind  <= K_POINT;
                            r_state <= S_MUL_GO;
                        end
                    end
                end
                S_RATE_GO:  r_state <= S_RATE_DIV;
                S_RATE_DIV: if (!i_sts.div_busy) r_state <= S_HP0_DIV;
                S_HP0_DIV:  if (!i_sts.div_busy) r_state <= S_MUL_GO;
                S_MUL_GO:   r_state <= S_MUL;
                S_MUL:      if (!i_sts.mul_busy) r_state <= S_NEXT_GO;
                S_NEXT_GO:  r_state <= S_NEXT_DIV;
                S_NEXT_DIV: if (!i_sts.div_busy) r_state <= S_DECIDE;
                S_DECIDE:   r_state <= S_EMIT;
                S_EMIT:     if (out_free) r_state <= S_IDLE;
                default:    r_state <= S_IDLE;
            endcase
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_cmd       = cmd;

    // Conditions watched by the checks below.
    assign units_busy = i_sts.div_busy || i_sts.mul_busy;
    assign err_emit   = cmd.emit && (r_kind != K_POINT);
    assign mid_emit   = cmd.emit && (r_kind == K_POINT) && !i_sts.last;

    `CSW_ASSERT_SAME(a_div_start_idle, cmd.div_go, !i_sts.div_busy, "divider busy at start")
    `CSW_ASSERT_SAME(a_idle_units_free, r_state == S_IDLE, !units_busy, "unit busy in idle")
    `CSW_ASSERT_NEXT(a_error_stops, err_emit, !r_running, "running after error")
    `CSW_ASSERT_NEXT(a_point_keeps, mid_emit, r_running, "sweep stopped early")
endmodule

// File: rtl/chirp_square_wave_points_core.sv
// Top level of the linear chirp square wave point generator.
// Each request returns one point of a bipolar square wave whose frequency sweeps
// linearly over the programmed period; restart=1 begins a new sweep. A point runs
// a bit-serial multiply of the sweep rate by the half period, then a bit-serial
// division for the next half period. A restart adds two more divisions (sweep rate
// and first half period). Error results (idle, invalid start, too many points) go
// straight to the result register without using the arithmetic units.
// Configuration writes are accepted at any time and must be made only while idle.
module chirp_square_wave_points_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    csw_in_if.sink      i_in,
    csw_out_if.source   o_out,
    csw_cfg_if.sink     i_cfg
);
    import csw_pkg::*;

    t_cmd cmd;
    t_sts sts;

    assign i_cfg.ready = 1'b1;

    csw_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .i_restart   (i_in.restart),
        .o_in_ready  (i_in.ready),
        .o_out_valid (o_out.valid),
        .i_out_ready (o_out.ready),
        .o_cmd       (cmd),
        .i_sts       (sts)
    );

    csw_dp u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg.valid),
        .i_cfg_index      (i_cfg.index),
        .i_cfg_data       (i_cfg.data),
        .i_cmd            (cmd),
        .o_sts            (sts),
        .o_level          (o_out.level),
        .o_duration_ticks (o_out.duration_ticks),
        .o_last           (o_out.last),
        .o_status         (o_out.status)
    );
endmodule
